// ===== rtl/epicycloid_point_generator_top_assert.svh =====
// Assertion macros used by the epicycloid point generator controller.
`ifndef EPICYCLOID_POINT_GENERATOR_TOP_ASSERT_SVH
`define EPICYCLOID_POINT_GENERATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define EPG_ASSERT_IMPLY(label, aclk, arst, ante, cons) \
  label: assert property (@(posedge aclk) disable iff (arst) (ante) |-> (cons)) \
    else $error("epg: same-cycle check failed");

`define EPG_ASSERT_NEXT(label, aclk, arst, ante, cons) \
  label: assert property (@(posedge aclk) disable iff (arst) (ante) |=> (cons)) \
    else $error("epg: next-cycle check failed");

`else

`define EPG_ASSERT_IMPLY(label, aclk, arst, ante, cons)

`define EPG_ASSERT_NEXT(label, aclk, arst, ante, cons)

`endif

`endif

// ===== rtl/epg_pkg.sv =====
// Package: widths, constants, codes and the arctangent table of the point generator.
package epg_pkg;

  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_ITERS_DEF = 16;

  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int COORD_W     = 26;
  localparam int TURN_W      = 32;
  localparam int CORDIC_W    = 34;
  localparam int TRIG_W      = 32;
  localparam int K1_W        = 17;
  localparam int AMP_W       = 25;
  localparam int MUL_A_W     = 26;
  localparam int PROD_W      = MUL_A_W + TRIG_W;
  localparam int ATAN_IDX_W  = 5;
  localparam int FRAC_SHIFT  = 30;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [PROD_W-1:0]   ROUND_HALF  = 58'sd536870912;
  localparam logic [K1_W-1:0]            K1_ONE      = 17'd256;

  // register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS      = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RATIO       = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_POINT_COUNT = 8'd3;

  localparam logic [CFG_W-1:0] RADIUS_RST      = 16'd4096;
  localparam logic [CFG_W-1:0] RATIO_RST       = 16'd768;
  localparam logic [CFG_W-1:0] PHASE_STEP_RST  = 16'd522;
  localparam logic [CFG_W-1:0] POINT_COUNT_RST = 16'd180;

  // product/accumulate sequence
  localparam int MUL_STEP_W = 3;
  localparam logic [MUL_STEP_W-1:0] MUL_AMP_C1 = 3'd0;
  localparam logic [MUL_STEP_W-1:0] MUL_R_C2   = 3'd1;
  localparam logic [MUL_STEP_W-1:0] MUL_AMP_S1 = 3'd2;
  localparam logic [MUL_STEP_W-1:0] MUL_R_S2   = 3'd3;
  localparam logic [MUL_STEP_W-1:0] MUL_FINISH = 3'd4;

  typedef struct packed {
    logic                  accept;
    logic                  prep;
    logic                  cordic_step;
    logic                  swap;
    logic                  save2;
    logic                  mul_en;
    logic [MUL_STEP_W-1:0] mul_step;
    logic                  out_load;
  } epg_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } epg_status_t;

  // atan(2^-i) in turns scaled by 2^32; zero past the table
  function automatic logic signed [CORDIC_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] i);
    logic signed [CORDIC_W-1:0] a;
    case (i)
      5'd0:    a = 34'sd536870912;
      5'd1:    a = 34'sd316933406;
      5'd2:    a = 34'sd167458907;
      5'd3:    a = 34'sd85004756;
      5'd4:    a = 34'sd42667331;
      5'd5:    a = 34'sd21354465;
      5'd6:    a = 34'sd10679838;
      5'd7:    a = 34'sd5340245;
      5'd8:    a = 34'sd2670163;
      5'd9:    a = 34'sd1335087;
      5'd10:   a = 34'sd667544;
      5'd11:   a = 34'sd333772;
      5'd12:   a = 34'sd166886;
      5'd13:   a = 34'sd83443;
      5'd14:   a = 34'sd41722;
      5'd15:   a = 34'sd20861;
      5'd16:   a = 34'sd10430;
      5'd17:   a = 34'sd5215;
      5'd18:   a = 34'sd2608;
      5'd19:   a = 34'sd1304;
      5'd20:   a = 34'sd652;
      5'd21:   a = 34'sd326;
      5'd22:   a = 34'sd163;
      5'd23:   a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/epg_in_if.sv =====
// Interfaces: input item, result point and configuration write channels.
interface epg_in_if import epg_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface epg_out_if import epg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      last_point;
  modport source (output valid, output point_x, output point_y, output last_point, input ready);
  modport sink (input valid, input point_x, input point_y, input last_point, output ready);
endinterface

interface epg_cfg_if import epg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_W-1:0]       data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/epicycloid_point_generator_top.sv =====
// Top level: epicycloid point generator, controller plus datapath.
//
//   channel  modport  payload                          accepted when
//   -------  -------  -------------------------------  -----------------------
//   item     sink     restart                          item.valid & item.ready
//   point    source   point_x, point_y, last_point     point.valid & point.ready
//   cfg      sink     index, data                      cfg.valid & cfg.ready
//
// From accept to the output register, a single CORDIC unit runs twice,
// one iteration per cycle. A setup step, a swap step and a save step sit
// around the two passes. Five steps on one shared multiplier and a load
// step follow.
// The next item can be taken no earlier than the cycle after the result
// is loaded. The point still waits in the output register while the next
// item is taken.
// rst is synchronous: it restores the register defaults and clears phase
// and point index. A stalled output holds the finished point in its final
// state until the output register frees up. cfg is always ready.
module epicycloid_point_generator_top import epg_pkg::*; #(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  epg_in_if.sink    item,
  epg_out_if.source point,
  epg_cfg_if.sink   cfg
);

  // iteration counter width follows the CORDIC length
  localparam int ITER_W = $clog2(CORDIC_ITERS);

  epg_cmd_t          cmd;
  epg_status_t       status;
  logic [ITER_W-1:0] iter;
  logic              in_ready;

  // take a new transaction only when the controller is idle
  assign item.ready = in_ready;

  epg_ctrl #(
    .CORDIC_ITERS(CORDIC_ITERS),
    .ITER_W      (ITER_W)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(item.valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd),
    .iter    (iter)
  );

  // datapath owns configuration, curve state, CORDIC, multiplier and output register
  epg_datapath #(
    .ANGLE_BITS  (ANGLE_BITS),
    .CORDIC_ITERS(CORDIC_ITERS),
    .ITER_W      (ITER_W)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .iter   (iter),
    .restart(item.restart),
    .status (status),
    .cfg    (cfg),
    .point  (point)
  );

endmodule

// ===== rtl/epg_cordic.sv =====
// Iterative rotation-mode CORDIC with half-turn folding, one iteration per cycle.
module epg_cordic import epg_pkg::*; #(
  parameter int CORDIC_ITERS = CORDIC_ITERS_DEF,
  parameter int ITER_W       = $clog2(CORDIC_ITERS)
) (
  input  logic                     clk,
  input  logic                     load,
  input  logic [TURN_W-1:0]        angle,
  input  logic                     step,
  input  logic [ITER_W-1:0]        iter,
  output logic signed [TRIG_W-1:0] cos_out,
  output logic signed [TRIG_W-1:0] sin_out
);

  logic signed [CORDIC_W-1:0] x;
  logic signed [CORDIC_W-1:0] y;
  logic signed [CORDIC_W-1:0] z;
  logic                       flip;

  logic                       flip_in;
  logic [TURN_W-1:0]          folded;
  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;
  logic signed [CORDIC_W-1:0] da;
  logic signed [CORDIC_W-1:0] xo;
  logic signed [CORDIC_W-1:0] yo;

  always_comb begin
    flip_in = angle[TURN_W-1] ^ angle[TURN_W-2];
    folded  = {angle[TURN_W-1] ^ flip_in, angle[TURN_W-2:0]};
    dx      = y >>> iter;
    dy      = x >>> iter;
    da      = atan_entry(ATAN_IDX_W'(iter));
    xo      = flip ? -x : x;
    yo      = flip ? -y : y;
  end

  assign cos_out = xo[TRIG_W-1:0];
  assign sin_out = yo[TRIG_W-1:0];

  always_ff @(posedge clk) begin
    if (load) begin
      flip <= flip_in;
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= CORDIC_W'(signed'(folded));
    end else if (step) begin
      if (!z[CORDIC_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - da;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + da;
      end
    end
  end

endmodule

// ===== rtl/epg_datapath.sv =====
// Datapath: configuration and phase registers, angle setup, CORDIC, multiply-accumulate, output.
module epg_datapath import epg_pkg::*; #(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_ITERS = CORDIC_ITERS_DEF,
  parameter int ITER_W       = $clog2(CORDIC_ITERS)
) (
  input  logic              clk,
  input  logic              rst,
  input  epg_cmd_t          cmd,
  input  logic [ITER_W-1:0] iter,
  input  logic              restart,
  output epg_status_t       status,
  epg_cfg_if.sink           cfg,
  epg_out_if.source         point
);

  // configuration
  logic [CFG_W-1:0] radius;
  logic [CFG_W-1:0] ratio;
  logic [CFG_W-1:0] phase_step;
  logic [CFG_W-1:0] point_count;

  // curve state
  logic [ANGLE_BITS-1:0] phase;
  logic [CFG_W-1:0]      point_index;

  // per-item work registers
  logic [ANGLE_BITS-1:0]     work_phase;
  logic                      work_last;
  logic [TURN_W-1:0]         u_angle;
  logic [AMP_W-1:0]          amp;
  logic signed [TRIG_W-1:0]  c1;
  logic signed [TRIG_W-1:0]  s1;
  logic signed [TRIG_W-1:0]  c2;
  logic signed [TRIG_W-1:0]  s2;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  acc_x;
  logic signed [PROD_W-1:0]  acc_y;

  logic [K1_W-1:0]              k1;
  logic [ANGLE_BITS-1:0]        phase_eff;
  logic [CFG_W-1:0]             index_eff;
  logic [CFG_W-1:0]             index_inc;
  logic                         last_eff;
  logic [31:0]                  step_wide;
  logic [ANGLE_BITS-1:0]        step_ab;
  logic [K1_W+ANGLE_BITS-1:0]   kp;
  logic [63:0]                  kp_wide;
  logic [CFG_W+K1_W-1:0]        rk;
  logic [TURN_W-1:0]            t32;
  logic [TURN_W-1:0]            cordic_angle;
  logic signed [TRIG_W-1:0]     cos_v;
  logic signed [TRIG_W-1:0]     sin_v;
  logic signed [MUL_A_W-1:0]    mul_a;
  logic signed [TRIG_W-1:0]     mul_b;

  always_comb begin
    k1        = {1'b0, ratio} + K1_ONE;
    phase_eff = restart ? '0 : phase;
    index_eff = restart ? '0 : point_index;
    index_inc = index_eff + 1'b1;
    last_eff  = (index_inc == point_count);
    step_wide = {16'b0, phase_step};
    step_ab   = step_wide[ANGLE_BITS-1:0];
    kp        = k1 * work_phase;
    kp_wide   = 64'(kp) << (24 - ANGLE_BITS);
    rk        = radius * k1;
    t32       = TURN_W'(work_phase) << (TURN_W - ANGLE_BITS);
    cordic_angle = cmd.prep ? t32 : u_angle;
  end

  epg_cordic #(
    .CORDIC_ITERS(CORDIC_ITERS),
    .ITER_W      (ITER_W)
  ) u_cordic (
    .clk    (clk),
    .load   (cmd.prep | cmd.swap),
    .angle  (cordic_angle),
    .step   (cmd.cordic_step),
    .iter   (iter),
    .cos_out(cos_v),
    .sin_out(sin_v)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= RADIUS_RST;
      ratio       <= RATIO_RST;
      phase_step  <= PHASE_STEP_RST;
      point_count <= POINT_COUNT_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_RADIUS:      radius      <= cfg.data;
        REG_RATIO:       ratio       <= cfg.data;
        REG_PHASE_STEP:  phase_step  <= cfg.data;
        REG_POINT_COUNT: point_count <= cfg.data;
        default:         ;
      endcase
    end
  end

  // phase and index advance as soon as the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      point_index <= '0;
    end else if (cmd.accept) begin
      phase       <= last_eff ? '0 : phase_eff + step_ab;
      point_index <= last_eff ? '0 : index_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      work_phase <= phase_eff;
      work_last  <= last_eff;
    end
    if (cmd.prep) begin
      u_angle <= kp_wide[TURN_W-1:0];
      amp     <= rk[CFG_W+K1_W-1:8];
    end
    if (cmd.swap) begin
      c1 <= cos_v;
      s1 <= sin_v;
    end
    if (cmd.save2) begin
      c2 <= cos_v;
      s2 <= sin_v;
    end
  end

  // one shared multiplier; odd steps take the radius, even steps the amplitude
  always_comb begin
    mul_a = cmd.mul_step[0] ? MUL_A_W'(signed'({1'b0, radius}))
                            : MUL_A_W'(signed'({1'b0, amp}));
    case (cmd.mul_step)
      MUL_AMP_C1: mul_b = c1;
      MUL_R_C2:   mul_b = c2;
      MUL_AMP_S1: mul_b = s1;
      MUL_R_S2:   mul_b = s2;
      default:    mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
      case (cmd.mul_step)
        MUL_R_C2:   acc_x <= prod + ROUND_HALF;
        MUL_AMP_S1: acc_x <= acc_x - prod;
        MUL_R_S2:   acc_y <= prod + ROUND_HALF;
        MUL_FINISH: acc_y <= acc_y - prod;
        default:    ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      point.valid <= 1'b0;
    end else if (cmd.out_load) begin
      point.valid <= 1'b1;
    end else if (point.ready) begin
      point.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      point.point_x    <= acc_x[FRAC_SHIFT+COORD_W-1:FRAC_SHIFT];
      point.point_y    <= acc_y[FRAC_SHIFT+COORD_W-1:FRAC_SHIFT];
      point.last_point <= work_last;
    end
  end

  assign status.out_blocked = point.valid & ~point.ready;

endmodule

// ===== rtl/epg_ctrl.sv =====
// Controller: sequences angle setup, both CORDIC passes, the products and the output load.
module epg_ctrl import epg_pkg::*; #(
  parameter int CORDIC_ITERS = CORDIC_ITERS_DEF,
  parameter int ITER_W       = $clog2(CORDIC_ITERS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  epg_status_t       status,
  output epg_cmd_t          cmd,
  output logic [ITER_W-1:0] iter
);

`include "epicycloid_point_generator_top_assert.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_ROT1  = 3'd2;
  localparam logic [2:0] S_SWAP  = 3'd3;
  localparam logic [2:0] S_ROT2  = 3'd4;
  localparam logic [2:0] S_SAVE2 = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERS - 1);

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [ITER_W-1:0]     iter_next;
  logic [MUL_STEP_W-1:0] mstep;
  logic [MUL_STEP_W-1:0] mstep_next;

  always_comb begin
    state_next = state;
    iter_next  = iter;
    mstep_next = mstep;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        iter_next  = '0;
        state_next = S_ROT1;
      end
      S_ROT1: begin
        cmd.cordic_step = 1'b1;
        iter_next       = iter + 1'b1;
        if (iter == ITER_LAST) begin
          iter_next  = '0;
          state_next = S_SWAP;
        end
      end
      S_SWAP: begin
        cmd.swap   = 1'b1;
        state_next = S_ROT2;
      end
      S_ROT2: begin
        cmd.cordic_step = 1'b1;
        iter_next       = iter + 1'b1;
        if (iter == ITER_LAST) begin
          iter_next  = '0;
          state_next = S_SAVE2;
        end
      end
      S_SAVE2: begin
        cmd.save2  = 1'b1;
        mstep_next = MUL_AMP_C1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = mstep;
        mstep_next   = mstep + 1'b1;
        if (mstep == MUL_FINISH) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register can take the point
        if (!status.out_blocked) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
      mstep <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
      mstep <= mstep_next;
    end
  end

  `EPG_ASSERT_NEXT(a_accept_to_prep, clk, rst, cmd.accept, state == S_PREP)
  `EPG_ASSERT_IMPLY(a_load_when_free, clk, rst, cmd.out_load, !status.out_blocked)
  `EPG_ASSERT_NEXT(a_rot1_to_swap, clk, rst, (state == S_ROT1) && (iter == ITER_LAST), state == S_SWAP)
  `EPG_ASSERT_IMPLY(a_mul_step_range, clk, rst, cmd.mul_en, cmd.mul_step <= MUL_FINISH)

endmodule
